### rtl/bpfa_pkg.sv
// Package of the bitmap page frame allocator: sizes, command codes and word helpers.
// Used by bitmap_page_frame_allocator_top; depends on nothing.
package bpfa_pkg;

  localparam int NUM_PAGES     = 65536;
  localparam int MAP_WORD_BITS = 64;
  localparam int MAP_WORDS     = (NUM_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int WORD_AW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W         = $clog2(MAP_WORD_BITS);
  localparam int PAGE_W        = $clog2(NUM_PAGES);
  localparam int EXT_W         = (PAGE_W + 1 > 18) ? PAGE_W + 1 : 18;
  localparam int DELTA_W       = $clog2(MAP_WORD_BITS + 1);

  localparam int KIND_W  = 3;
  localparam int IDX_W   = 16;
  localparam int REG_W   = 17;
  localparam int CNT_W   = 18;
  localparam int FREE_W  = 19;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [REG_W-1:0] REG_RESET = 17'h10000;

  localparam logic [KIND_W-1:0] KIND_REQUEST = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LOCK    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FREE    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RESERVE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd4;

  localparam logic REG_TRACKED = 1'b0;
  localparam logic REG_TOTAL   = 1'b1;

  typedef logic [MAP_WORD_BITS-1:0] map_word_t;

  function automatic logic [BIT_W-1:0] lowest_set(input map_word_t w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [DELTA_W-1:0] popcount(input map_word_t w);
    logic [DELTA_W-1:0] n;
    n = '0;
    for (int i = 0; i < MAP_WORD_BITS; i++) begin
      n = n + DELTA_W'(w[i]);
    end
    return n;
  endfunction

endpackage

### rtl/bpfa_map_ram.sv
// Single-port-write, single-port-read synchronous RAM holding the page busy map.
// Read data is registered in the cycle after a read with re_i high; no dependencies.
module bpfa_map_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 64,
  parameter int AW    = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### rtl/bitmap_page_frame_allocator_top.sv
// Top level of the first-fit bitmap page frame allocator.
// Depends on bpfa_pkg and bpfa_map_ram.
//
// After reset the block clears its busy map, one map word per cycle, and holds
// busy_o high until it is done. A command is taken when start_i is high and
// busy_o is low. The map is read, modified and written back one 64-page word
// per cycle through a memory with registered read data: a request scans from
// word 0 up to the word that holds its first free page, at most 1024 words; a
// range command visits each word its range covers. Empty ranges and unknown
// kinds skip the map and go straight to the result. Each result beat is shown
// for exactly one cycle with done_o high and cannot be held off by the
// receiver.
module bitmap_page_frame_allocator_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [bpfa_pkg::KIND_W-1:0]          kind_i,
  input  logic [bpfa_pkg::IDX_W-1:0]           page_index_i,
  input  logic [bpfa_pkg::REG_W-1:0]           page_count_i,
  output logic                                 done_o,
  output logic                                 found_o,
  output logic [bpfa_pkg::IDX_W-1:0]           granted_page_o,
  output logic signed [bpfa_pkg::CNT_W-1:0]    used_pages_o,
  output logic signed [bpfa_pkg::CNT_W-1:0]    reserved_pages_o,
  output logic signed [bpfa_pkg::FREE_W-1:0]   free_pages_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [bpfa_pkg::APB_AW-1:0]          paddr,
  input  logic [bpfa_pkg::APB_DW-1:0]          pwdata,
  output logic [bpfa_pkg::APB_DW-1:0]          prdata,
  output logic                                 pready
);

  import bpfa_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_CNT   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state_q, state_d;

  logic [REG_W-1:0] tracked_q, total_q;
  logic             cfg_wr;

  logic [WORD_AW-1:0] ptr_q, ptr_d;
  logic               iss_q, iss_d;
  logic               pend_q, pend_d;
  logic [WORD_AW-1:0] paddr_q, paddr_d;
  logic [WORD_AW-1:0] first_word_q, first_word_d;
  logic [WORD_AW-1:0] last_word_q, last_word_d;
  logic [BIT_W-1:0]   lo_bit_q, lo_bit_d;
  logic [BIT_W-1:0]   hi_bit_q, hi_bit_d;
  logic               req_q, req_d;
  logic               mark_q, mark_d;
  logic               sel_res_q, sel_res_d;

  logic [DELTA_W-1:0] delta_q, delta_d;
  logic               dv_q, dv_d;
  logic [CNT_W-1:0]   used_q, used_d;
  logic [CNT_W-1:0]   res_q, res_d;

  logic               found_q, found_d;
  logic [IDX_W-1:0]   grant_q, grant_d;
  logic               done_q, done_d;
  logic [FREE_W-1:0]  free_q, free_d;

  logic               mem_we, mem_re;
  logic [WORD_AW-1:0] mem_waddr;
  map_word_t          mem_wdata, mem_rdata;

  logic [EXT_W-1:0] lim, rng_end, rng_hi, lo_s, hi_s, hi_m1;
  logic             is_req, kind_ok;
  map_word_t        word_mask, cand;
  logic [BIT_W-1:0] hi_shift, pick;
  logic [CNT_W-1:0] cnt_sel, cnt_step;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tracked_q <= REG_RESET;
      total_q   <= REG_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_TRACKED: tracked_q <= pwdata[REG_W-1:0];
        REG_TOTAL:   total_q   <= pwdata[REG_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TRACKED: prdata = APB_DW'(tracked_q);
      REG_TOTAL:   prdata = APB_DW'(total_q);
      default:     prdata = '0;
    endcase
  end

  bpfa_map_ram #(
    .DEPTH(MAP_WORDS),
    .WIDTH(MAP_WORD_BITS),
    .AW   (WORD_AW)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(ptr_q),
    .rdata_o(mem_rdata)
  );

  // Command decode and range bounds, taken at the accepting edge.
  always_comb begin
    is_req  = (kind_i == KIND_REQUEST);
    kind_ok = (kind_i == KIND_REQUEST) || (kind_i == KIND_LOCK) || (kind_i == KIND_FREE) ||
              (kind_i == KIND_RESERVE) || (kind_i == KIND_RELEASE);
    lim     = (EXT_W'(tracked_q) < EXT_W'(NUM_PAGES)) ? EXT_W'(tracked_q) : EXT_W'(NUM_PAGES);
    rng_end = EXT_W'(page_index_i) + EXT_W'(page_count_i);
    rng_hi  = (rng_end < EXT_W'(NUM_PAGES)) ? rng_end : EXT_W'(NUM_PAGES);
    lo_s    = is_req ? '0 : EXT_W'(page_index_i);
    hi_s    = is_req ? lim : rng_hi;
    hi_m1   = hi_s - EXT_W'(1);
  end

  // Pages of the word in flight that the command covers.
  always_comb begin
    hi_shift  = BIT_W'(MAP_WORD_BITS - 1) - hi_bit_q;
    word_mask = '1;
    if (paddr_q == first_word_q) begin
      word_mask = word_mask & (map_word_t'('1) << lo_bit_q);
    end
    if (paddr_q == last_word_q) begin
      word_mask = word_mask & (map_word_t'('1) >> hi_shift);
    end
    cand = ~mem_rdata & word_mask;
    pick = lowest_set(cand);
  end

  always_comb begin
    state_d      = state_q;
    ptr_d        = ptr_q;
    iss_d        = iss_q;
    pend_d       = 1'b0;
    paddr_d      = paddr_q;
    first_word_d = first_word_q;
    last_word_d  = last_word_q;
    lo_bit_d     = lo_bit_q;
    hi_bit_d     = hi_bit_q;
    req_d        = req_q;
    mark_d       = mark_q;
    sel_res_d    = sel_res_q;
    delta_d      = delta_q;
    dv_d         = 1'b0;
    found_d      = found_q;
    grant_d      = grant_q;
    done_d       = 1'b0;
    free_d       = free_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = paddr_q;
    mem_wdata    = '0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        if (ptr_q == WORD_AW'(MAP_WORDS - 1)) begin
          state_d = S_IDLE;
          ptr_d   = '0;
        end else begin
          ptr_d = ptr_q + WORD_AW'(1);
        end
      end
      S_IDLE: begin
        if (start_i) begin
          found_d      = 1'b0;
          grant_d      = '0;
          req_d        = is_req;
          mark_d       = (kind_i == KIND_REQUEST) || (kind_i == KIND_LOCK) ||
                         (kind_i == KIND_RESERVE);
          sel_res_d    = (kind_i == KIND_RESERVE) || (kind_i == KIND_RELEASE);
          first_word_d = WORD_AW'(lo_s >> BIT_W);
          last_word_d  = WORD_AW'(hi_m1 >> BIT_W);
          lo_bit_d     = lo_s[BIT_W-1:0];
          hi_bit_d     = hi_m1[BIT_W-1:0];
          ptr_d        = WORD_AW'(lo_s >> BIT_W);
          if (kind_ok && (hi_s > lo_s)) begin
            iss_d   = 1'b1;
            state_d = S_RUN;
          end else begin
            iss_d   = 1'b0;
            state_d = S_CNT;
          end
        end
      end
      S_RUN: begin
        if (iss_q) begin
          mem_re  = 1'b1;
          pend_d  = 1'b1;
          paddr_d = ptr_q;
          if (ptr_q == last_word_q) begin
            iss_d = 1'b0;
          end else begin
            ptr_d = ptr_q + WORD_AW'(1);
          end
        end
        if (pend_q) begin
          if (req_q) begin
            if (|cand) begin
              mem_we    = 1'b1;
              mem_wdata = mem_rdata | (map_word_t'(1) << pick);
              found_d   = 1'b1;
              grant_d   = IDX_W'({paddr_q, pick});
              delta_d   = DELTA_W'(1);
              dv_d      = 1'b1;
              iss_d     = 1'b0;
              pend_d    = 1'b0;
              state_d   = S_CNT;
            end else if (paddr_q == last_word_q) begin
              pend_d  = 1'b0;
              state_d = S_CNT;
            end
          end else begin
            mem_we = 1'b1;
            dv_d   = 1'b1;
            if (mark_q) begin
              mem_wdata = mem_rdata | word_mask;
              delta_d   = popcount(cand);
            end else begin
              mem_wdata = mem_rdata & ~word_mask;
              delta_d   = popcount(mem_rdata & word_mask);
            end
            if (paddr_q == last_word_q) begin
              pend_d  = 1'b0;
              state_d = S_CNT;
            end
          end
        end
      end
      S_CNT: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        free_d  = FREE_W'({2'b00, total_q}) - FREE_W'({used_q[CNT_W-1], used_q}) -
                  FREE_W'({res_q[CNT_W-1], res_q});
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Count update comes in the cycle after the map write, from the registered delta_q.
  always_comb begin
    used_d   = used_q;
    res_d    = res_q;
    cnt_sel  = sel_res_q ? res_q : used_q;
    cnt_step = mark_q ? (cnt_sel + CNT_W'(delta_q)) : (cnt_sel - CNT_W'(delta_q));
    if (dv_q) begin
      if (sel_res_q) begin
        res_d = cnt_step;
      end else begin
        used_d = cnt_step;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ptr_q   <= '0;
      iss_q   <= 1'b0;
      pend_q  <= 1'b0;
      dv_q    <= 1'b0;
      done_q  <= 1'b0;
      used_q  <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      iss_q   <= iss_d;
      pend_q  <= pend_d;
      dv_q    <= dv_d;
      done_q  <= done_d;
      used_q  <= used_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    paddr_q      <= paddr_d;
    first_word_q <= first_word_d;
    last_word_q  <= last_word_d;
    lo_bit_q     <= lo_bit_d;
    hi_bit_q     <= hi_bit_d;
    req_q        <= req_d;
    mark_q       <= mark_d;
    sel_res_q    <= sel_res_d;
    delta_q      <= delta_d;
    found_q      <= found_d;
    grant_q      <= grant_d;
    free_q       <= free_d;
  end

  assign busy_o           = (state_q != S_IDLE);
  assign done_o           = done_q;
  assign found_o          = found_q;
  assign granted_page_o   = grant_q;
  assign used_pages_o     = $signed(used_q);
  assign reserved_pages_o = $signed(res_q);
  assign free_pages_o     = $signed(free_q);

endmodule
